// ----- src/fem_pkg.sv -----
// fault escalation manager package: sizes, function codes, fsm states, attribute layout
// no dependencies
`default_nettype none
package fem_pkg;
    localparam int PORTS  = 2;
    localparam int FAULTS = 32;
    localparam int LEVELS = 6;
    localparam int PW = 1;
    localparam int FW = 5;
    localparam int EW = PW + FW;

    typedef enum logic [2:0] {
        FN_RAISE = 3'd0, FN_CLEAR = 3'd1, FN_TICK = 3'd2, FN_LOAD = 3'd3, FN_QUERY = 3'd4
    } t_func;

    localparam logic [1:0] PERMIT_ALLOW   = 2'd0;
    localparam logic [1:0] PERMIT_SUSPEND = 2'd1;
    localparam logic [1:0] PERMIT_CANCEL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_OUT, ST_NEXT
    } t_state;

    typedef struct packed {
        logic        pile;
        logic [15:0] recov;
        logic        self_clr;
        logic [2:0]  final_lv;
        logic [2:0]  temp_lv;
        logic [7:0]  limit;
    } t_attr;

    // per-entry fault state word
    typedef struct packed {
        logic        act;
        logic [2:0]  lv;
        logic [7:0]  occ;
        logic [15:0] rec;
    } t_entry;

    function automatic logic [2:0] clamp_level(input logic [2:0] v);
        return (v >= 3'(LEVELS)) ? 3'(LEVELS - 1) : v;
    endfunction
endpackage
`default_nettype wire

// ----- src/fem_lvl_cnt.sv -----
// per-port level counters with saturating increment and floored decrement
// depends on fem_pkg; derives permit and serious flag for the selected read port
`default_nettype none
module fem_lvl_cnt import fem_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_inc,
    input  wire logic          i_dec,
    input  wire logic [PW-1:0] i_port,
    input  wire logic [2:0]    i_lv,
    input  wire logic [PW-1:0] i_rd_port,
    output logic [1:0]         o_permit,
    output logic               o_serious
);
    logic [7:0] r_cnt [PORTS][LEVELS];
    logic       u [LEVELS];

    // count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORTS; p++)
                for (int l = 0; l < LEVELS; l++) r_cnt[p][l] <= '0;
        end else if (i_inc && r_cnt[i_port][i_lv] != 8'hFF) begin
            r_cnt[i_port][i_lv] <= r_cnt[i_port][i_lv] + 8'd1;
        end else if (i_dec && r_cnt[i_port][i_lv] != 8'h00) begin
            r_cnt[i_port][i_lv] <= r_cnt[i_port][i_lv] - 8'd1;
        end
    end

    // permit and serious from levels in use
    always_comb begin
        for (int l = 0; l < LEVELS; l++) u[l] = (r_cnt[i_rd_port][l] != 8'd0);
        o_serious = u[3] | u[4] | u[5];
        if (u[1] | u[4] | u[5]) o_permit = PERMIT_CANCEL;
        else if (u[3])          o_permit = PERMIT_SUSPEND;
        else                    o_permit = PERMIT_ALLOW;
    end
endmodule
`default_nettype wire

// ----- src/fault_escalation_manager.sv -----
// fault escalation manager top level: sequencer, fault state and attribute memories
// depends on fem_pkg and fem_lvl_cnt
//
//  channel | direction | signals
//  in      | input     | i_valid/o_ready, i_func i_port i_err_id and load fields
//  out     | output    | o_valid/i_ready, o_out_port o_out_err ... o_last
//
// one item at a time; load and unused codes finish in the accept cycle. raise and clear
// then visit both ports, each visit through the read and exec states and then the out
// state for a changed entry or else the next state; query reads one addressed entry.
// a tick walks all 64 fault entries in the same way, port major. reset clears the fault
// state memory with a pass over all 64 entries before the first transfer. a stalled
// result holds the sequencer and the next transfer.
`default_nettype none
module fault_escalation_manager import fem_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_func,
    input  wire logic        i_port,
    input  wire logic [4:0]  i_err_id,
    input  wire logic [7:0]  i_occur_limit,
    input  wire logic [2:0]  i_temp_level,
    input  wire logic [2:0]  i_final_level,
    input  wire logic        i_self_clear,
    input  wire logic [15:0] i_recovery_ticks,
    input  wire logic        i_pile_wide,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_out_port,
    output logic [4:0]       o_out_err,
    output logic             o_active,
    output logic [2:0]       o_level,
    output logic [7:0]       o_occur_count,
    output logic [1:0]       o_permit,
    output logic             o_serious,
    output logic             o_last
);
    t_state r_state, n_state;
    t_entry mem_st [PORTS*FAULTS];
    t_attr  mem_at [FAULTS];
    t_entry r_st_q;
    t_attr  r_at_q;

    logic          r_clr, n_clr;
    logic [EW:0]   r_cidx, n_cidx;
    logic [2:0]    r_func, n_func;
    logic [PW-1:0] r_port, n_port;
    logic [FW-1:0] r_err, n_err;
    logic [EW:0]   r_idx, n_idx;       // walk counter, port major
    logic          r_pend, n_pend;     // held result not yet marked last

    logic          st_we;
    logic [EW-1:0] st_waddr;
    t_entry        st_wdata;
    logic [EW-1:0] st_raddr;
    logic          lc_inc, lc_dec;
    logic [2:0]    lc_lv;
    logic [1:0]    permit;
    logic          serious;

    logic [PW-1:0] cur_port;
    logic [FW-1:0] cur_err;
    logic          last_pos, in_scope, changed;
    logic [7:0]    occ_new;
    logic [15:0]   rec_new;
    logic [2:0]    lv_sel;
    t_entry        upd;

    // output register
    logic r_ov; logic r_op; logic [4:0] r_oe; logic r_oa; logic [2:0] r_ol;
    logic [7:0] r_oo; logic [1:0] r_opm; logic r_os; logic r_olast;
    logic load_out, set_last;

    assign cur_port = r_idx[EW-1:FW];
    assign cur_err  = (r_func == FN_TICK) ? r_idx[FW-1:0] : r_err;
    assign st_raddr = {cur_port, cur_err};

    fem_lvl_cnt u_lvl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(lc_inc), .i_dec(lc_dec),
        .i_port(cur_port), .i_lv(lc_lv), .i_rd_port(cur_port),
        .o_permit(permit), .o_serious(serious)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (st_we) mem_st[st_waddr] <= st_wdata;
        r_st_q <= mem_st[st_raddr];
        r_at_q <= mem_at[cur_err];
        if (o_ready && i_valid && i_func == FN_LOAD)
            mem_at[i_err_id] <= '{pile: i_pile_wide, recov: i_recovery_ticks,
                self_clr: i_self_clear, final_lv: clamp_level(i_final_level),
                temp_lv: clamp_level(i_temp_level), limit: i_occur_limit};
    end

    // entry update
    always_comb begin
        occ_new = r_st_q.occ;
        if (r_func == FN_RAISE && r_st_q.occ < r_at_q.limit) occ_new = r_st_q.occ + 8'd1;
        lv_sel   = (occ_new >= r_at_q.limit) ? r_at_q.final_lv : r_at_q.temp_lv;
        rec_new  = (r_st_q.rec != 16'hFFFF) ? r_st_q.rec + 16'd1 : r_st_q.rec;
        in_scope = (r_func == FN_TICK) || r_at_q.pile || (cur_port == r_port);
        upd      = r_st_q;
        changed  = 1'b0;
        case (r_func)
            FN_RAISE: if (in_scope && !r_st_q.act) begin
                changed = 1'b1;
                upd = '{act: 1'b1, lv: lv_sel, occ: occ_new, rec: 16'd0};
            end
            FN_CLEAR: if (in_scope && r_st_q.act) begin
                changed = 1'b1;
                upd.act = 1'b0; upd.lv = 3'd0;
            end
            FN_TICK: if (r_st_q.act && r_at_q.self_clr) begin
                upd.rec = rec_new;
                if (rec_new >= r_at_q.recov) begin
                    changed = 1'b1;
                    upd.act = 1'b0; upd.lv = 3'd0; upd.rec = 16'd0;
                end
            end
            default: ;
        endcase
        last_pos = (r_func == FN_TICK) ? (r_idx == (EW+1)'(PORTS*FAULTS - 1))
                 : (r_func == FN_QUERY) ? 1'b1
                 : (r_idx[EW-1:FW] == PW'(PORTS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_clr <= 1'b1; r_cidx <= '0;
            r_pend <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_cidx <= n_cidx;
            r_pend <= n_pend;
            if (load_out) r_ov <= 1'b1;
            else if (o_valid && i_ready) r_ov <= 1'b0;
        end
        r_func <= n_func; r_port <= n_port; r_err <= n_err; r_idx <= n_idx;
        if (load_out) begin
            r_op <= cur_port; r_oe <= cur_err;
            r_olast <= last_pos;
            if (r_func == FN_QUERY) begin
                r_oa <= r_st_q.act; r_ol <= r_st_q.lv; r_oo <= r_st_q.occ;
                r_opm <= permit; r_os <= serious;
            end else begin
                r_oa <= upd.act; r_ol <= upd.lv; r_oo <= upd.occ;
                r_opm <= permit; r_os <= serious;
            end
        end else if (set_last) begin
            r_olast <= 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_clr = r_clr; n_cidx = r_cidx;
        n_func = r_func; n_port = r_port; n_err = r_err; n_idx = r_idx;
        n_pend = r_pend;
        o_ready = 1'b0; st_we = 1'b0; st_waddr = st_raddr; st_wdata = upd;
        lc_inc = 1'b0; lc_dec = 1'b0; lc_lv = lv_sel;
        load_out = 1'b0; set_last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (r_clr) begin
                    st_we = 1'b1; st_waddr = r_cidx[EW-1:0]; st_wdata = '0;
                    n_cidx = r_cidx + 1'b1;
                    if (r_cidx == (EW+1)'(PORTS*FAULTS - 1)) n_clr = 1'b0;
                end else begin
                    o_ready = !r_ov;
                    if (i_valid && o_ready) begin
                        n_func = i_func; n_port = i_port; n_err = i_err_id;
                        n_pend = 1'b0;
                        n_idx = '0;
                        if (i_func == FN_QUERY) n_idx = {1'b0, i_port, {FW{1'b0}}};
                        if (i_func == FN_RAISE || i_func == FN_CLEAR
                            || i_func == FN_TICK || i_func == FN_QUERY)
                            n_state = ST_READ;
                    end
                end
            end
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: begin
                if (r_func == FN_QUERY) begin
                    if (!r_ov) begin load_out = 1'b1; n_state = ST_IDLE; end
                end else begin
                    st_we = 1'b1;
                    if (changed) begin
                        if (r_func == FN_RAISE) lc_inc = 1'b1;
                        else begin
                            lc_dec = 1'b1;
                            lc_lv = (r_st_q.occ >= r_at_q.limit) ? r_at_q.final_lv
                                                                 : r_at_q.temp_lv;
                        end
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_NEXT;
                    end
                end
            end
            ST_OUT: if (!r_ov) begin
                // counters now updated, capture result
                load_out = 1'b1;
                n_pend = !last_pos;
                n_state = last_pos ? ST_IDLE : ST_NEXT;
            end
            ST_NEXT: begin
                if (last_pos) begin
                    if (r_pend) begin
                        if (r_ov) set_last = 1'b1;
                    end
                    n_pend = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + (r_func == FN_TICK ? (EW+1)'(1) : (EW+1)'(1 << FW));
                    n_state = ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // a held result is shown once a later result follows it or the walk ends
    assign o_valid = r_ov & !(r_pend & (r_state != ST_IDLE) & (r_state != ST_OUT) & !r_olast);
    assign o_out_port = r_op; assign o_out_err = r_oe; assign o_active = r_oa;
    assign o_level = r_ol; assign o_occur_count = r_oo; assign o_permit = r_opm;
    assign o_serious = r_os; assign o_last = r_olast;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("accept while busy");
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_ready) else $error("accept during clearing pass");
    a_cnt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(lc_inc && lc_dec)) else $error("level count inc and dec together");
`endif
endmodule
`default_nettype wire

// ----- tb/fem_checker.sv -----
// fault escalation manager checker: watches both channels, predicts results, compares
// depends on fem_pkg
`default_nettype none
module fem_checker import fem_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_in_ready,
    input  wire logic [2:0]  i_func,
    input  wire logic        i_port,
    input  wire logic [4:0]  i_err_id,
    input  wire logic [7:0]  i_occur_limit,
    input  wire logic [2:0]  i_temp_level,
    input  wire logic [2:0]  i_final_level,
    input  wire logic        i_self_clear,
    input  wire logic [15:0] i_recovery_ticks,
    input  wire logic        i_pile_wide,
    input  wire logic        i_out_valid,
    input  wire logic        i_ready,
    input  wire logic        i_out_port,
    input  wire logic [4:0]  i_out_err,
    input  wire logic        i_active,
    input  wire logic [2:0]  i_level,
    input  wire logic [7:0]  i_occur_count,
    input  wire logic [1:0]  i_permit,
    input  wire logic        i_serious,
    input  wire logic        i_last,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       port;
        logic [4:0] err;
        logic       act;
        logic [2:0] lv;
        logic [7:0] occ;
        logic [1:0] permit;
        logic       serious;
        logic       last;
    } t_status;

    // shadow fault state
    logic        act_m [PORTS][FAULTS];
    logic [7:0]  occ_m [PORTS][FAULTS];
    logic [2:0]  lv_m  [PORTS][FAULTS];
    logic [15:0] rec_m [PORTS][FAULTS];
    logic [7:0]  lvl_cnt [PORTS][LEVELS];
    logic [1:0]  permit_m [PORTS];
    t_attr       attr_m [FAULTS];
    t_status     status_q [$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = status_q.size();

    function automatic logic serious_of(input int p);
        return (lvl_cnt[p][3] != 0) || (lvl_cnt[p][4] != 0) || (lvl_cnt[p][5] != 0);
    endfunction

    function automatic void update_permit(input int p);
        if (lvl_cnt[p][1] != 0 || lvl_cnt[p][4] != 0 || lvl_cnt[p][5] != 0)
            permit_m[p] = PERMIT_CANCEL;
        else if (lvl_cnt[p][3] != 0)
            permit_m[p] = PERMIT_SUSPEND;
        else
            permit_m[p] = PERMIT_ALLOW;
    endfunction

    function automatic logic [2:0] level_for(input int p, input int f);
        return (occ_m[p][f] >= attr_m[f].limit) ? attr_m[f].final_lv : attr_m[f].temp_lv;
    endfunction

    function automatic void push_status(input int p, input int f);
        t_status s;
        s = '{port: 1'(p), err: 5'(f), act: act_m[p][f], lv: lv_m[p][f],
              occ: occ_m[p][f], permit: permit_m[p], serious: serious_of(p), last: 1'b0};
        status_q.push_back(s);
    endfunction

    function automatic logic raise_fault(input int p, input int f);
        logic [2:0] l;
        if (act_m[p][f]) return 1'b0;
        act_m[p][f] = 1'b1;
        rec_m[p][f] = '0;
        if (occ_m[p][f] < attr_m[f].limit) occ_m[p][f]++;
        l = level_for(p, f);
        lv_m[p][f] = l;
        if (lvl_cnt[p][l] != 8'hff) lvl_cnt[p][l]++;
        update_permit(p);
        return 1'b1;
    endfunction

    function automatic logic clear_fault(input int p, input int f);
        logic [2:0] l;
        if (!act_m[p][f]) return 1'b0;
        act_m[p][f] = 1'b0;
        l = level_for(p, f);
        if (lvl_cnt[p][l] != 0) lvl_cnt[p][l]--;
        lv_m[p][f] = '0;
        update_permit(p);
        return 1'b1;
    endfunction

    // expected results of one accepted input transfer
    function automatic void predict_status(input logic [2:0] fn, input int port, input int f);
        int n0;
        t_status s;
        n0 = status_q.size();
        case (fn)
            FN_RAISE, FN_CLEAR: begin
                for (int p = 0; p < PORTS; p++) begin
                    if (!attr_m[f].pile && p != port) continue;
                    if (fn == FN_RAISE ? raise_fault(p, f) : clear_fault(p, f))
                        push_status(p, f);
                end
            end
            FN_TICK: begin
                for (int p = 0; p < PORTS; p++)
                    for (int g = 0; g < FAULTS; g++) begin
                        if (!act_m[p][g] || !attr_m[g].self_clr) continue;
                        if (rec_m[p][g] != 16'hffff) rec_m[p][g]++;
                        if (rec_m[p][g] >= attr_m[g].recov) begin
                            rec_m[p][g] = '0;
                            if (clear_fault(p, g)) push_status(p, g);
                        end
                    end
            end
            FN_LOAD: begin
                attr_m[f] = '{pile: i_pile_wide, recov: i_recovery_ticks,
                              self_clr: i_self_clear,
                              final_lv: (i_final_level >= LEVELS) ? 3'(LEVELS-1) : i_final_level,
                              temp_lv: (i_temp_level >= LEVELS) ? 3'(LEVELS-1) : i_temp_level,
                              limit: i_occur_limit};
            end
            FN_QUERY: push_status(port, f);
            default: ;
        endcase
        if (status_q.size() > n0) begin
            s = status_q.pop_back();
            s.last = 1'b1;
            status_q.push_back(s);
        end
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // watch both channels
    always @(posedge i_clk) begin
        t_status got, want;
        if (!i_rst_n) begin
            for (int p = 0; p < PORTS; p++) begin
                for (int f = 0; f < FAULTS; f++) begin
                    act_m[p][f] = 0; occ_m[p][f] = 0; lv_m[p][f] = 0; rec_m[p][f] = 0;
                end
                for (int l = 0; l < LEVELS; l++) lvl_cnt[p][l] = 0;
                permit_m[p] = PERMIT_ALLOW;
            end
            for (int f = 0; f < FAULTS; f++) attr_m[f] = '0;
            status_q.delete();
            errors = 0;
        end else begin
            if (i_out_valid && i_ready) begin
                got = '{i_out_port, i_out_err, i_active, i_level, i_occur_count,
                        i_permit, i_serious, i_last};
                if (status_q.size() == 0) begin
                    report($sformatf("unexpected result %p", got));
                end else begin
                    want = status_q.pop_front();
                    if (got.port != want.port) report($sformatf("port %0d want %0d", got.port, want.port));
                    if (got.err != want.err) report($sformatf("err %0d want %0d", got.err, want.err));
                    if (got.act != want.act) report($sformatf("active %0d want %0d", got.act, want.act));
                    if (got.lv != want.lv) report($sformatf("level %0d want %0d", got.lv, want.lv));
                    if (got.occ != want.occ) report($sformatf("occur %0d want %0d", got.occ, want.occ));
                    if (got.permit != want.permit)
                        report($sformatf("permit %0d want %0d", got.permit, want.permit));
                    if (got.serious != want.serious)
                        report($sformatf("serious %0d want %0d", got.serious, want.serious));
                    if (got.last != want.last) report($sformatf("last %0d want %0d", got.last, want.last));
                end
            end
            if (i_valid && i_in_ready)
                predict_status(i_func, i_port, i_err_id);
        end
    end
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// fault escalation manager testbench top: clock, reset, stimulus and verdict
// depends on fem_pkg, fem_checker and the fault_escalation_manager rtl
`default_nettype none
module tb;
    import fem_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic        clk = 0, rst_n = 0;
    logic        in_valid = 0, in_ready, out_valid, out_ready = 0;
    logic [2:0]  func = '0;
    logic        port = 0;
    logic [4:0]  err_id = '0;
    logic [7:0]  occur_limit = '0;
    logic [2:0]  temp_level = '0, final_level = '0;
    logic        self_clear = 0;
    logic [15:0] recovery_ticks = '0;
    logic        pile_wide = 0;
    logic        out_port, active, serious, last;
    logic [4:0]  out_err;
    logic [2:0]  level;
    logic [7:0]  occur_count;
    logic [1:0]  permit;
    int          errors, pending;
    int          idle_cycles = 0;
    bit          loaded [FAULTS];
    int          gap_left, burst_left;

    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    fault_escalation_manager uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_func(func), .i_port(port), .i_err_id(err_id), .i_occur_limit(occur_limit),
        .i_temp_level(temp_level), .i_final_level(final_level), .i_self_clear(self_clear),
        .i_recovery_ticks(recovery_ticks), .i_pile_wide(pile_wide),
        .o_valid(out_valid), .i_ready(out_ready), .o_out_port(out_port), .o_out_err(out_err),
        .o_active(active), .o_level(level), .o_occur_count(occur_count), .o_permit(permit),
        .o_serious(serious), .o_last(last)
    );

    fem_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_ready(in_ready),
        .i_func(func), .i_port(port), .i_err_id(err_id), .i_occur_limit(occur_limit),
        .i_temp_level(temp_level), .i_final_level(final_level), .i_self_clear(self_clear),
        .i_recovery_ticks(recovery_ticks), .i_pile_wide(pile_wide),
        .i_out_valid(out_valid), .i_ready(out_ready), .i_out_port(out_port),
        .i_out_err(out_err), .i_active(active), .i_level(level),
        .i_occur_count(occur_count), .i_permit(permit), .i_serious(serious), .i_last(last),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern: phases of free flow, light and heavy back-pressure
    always @(posedge clk) begin
        int phase;
        phase = int'(($time / 4000) % 3);
        if (phase == 0) out_ready <= 1'b1;
        else if (phase == 1) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= ($urandom_range(0, 3) == 0);
    end

    // watchdog on transfers
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one transfer on the input channel, with burst gaps ahead of it
    task automatic send_item(input logic [2:0] fn, input logic p, input logic [4:0] e,
                             input logic [7:0] lim, input logic [2:0] tl,
                             input logic [2:0] fl, input logic sc,
                             input logic [15:0] rt, input logic pw);
        if (burst_left == 0) begin
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 10);
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                repeat (gap_left) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1; func <= fn; port <= p; err_id <= e;
        occur_limit <= lim; temp_level <= tl; final_level <= fl;
        self_clear <= sc; recovery_ticks <= rt; pile_wide <= pw;
        if (fn == FN_LOAD) loaded[e] = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_op(input logic [2:0] fn, input logic p, input logic [4:0] e);
        send_item(fn, p, e, 8'($urandom), 3'($urandom), 3'($urandom), 1'($urandom),
                  16'($urandom), 1'($urandom));
    endtask

    task automatic load_fault(input logic [4:0] e, input logic [7:0] lim, input logic [2:0] tl,
                              input logic [2:0] fl, input logic sc, input logic [15:0] rt,
                              input logic pw);
        send_item(FN_LOAD, 1'($urandom), e, lim, tl, fl, sc, rt, pw);
    endtask

    // random fault index that has an attribute entry
    function automatic logic [4:0] pick_loaded();
        logic [4:0] e;
        do e = 5'($urandom); while (!loaded[e]);
        return e;
    endfunction

    initial begin
        logic [4:0] e;
        int k;
        burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every function, special cases
        load_fault(5'd0, 8'd0, 3'd7, 3'd7, 1'b1, 16'd0, 1'b0);
        load_fault(5'd31, 8'd255, 3'd1, 3'd5, 1'b0, 16'hffff, 1'b1);
        load_fault(5'd1, 8'd2, 3'd3, 3'd4, 1'b1, 16'd2, 1'b1);
        load_fault(5'd2, 8'd1, 3'd6, 3'd0, 1'b1, 16'd1, 1'b0);
        send_op(FN_RAISE, 1'b0, 5'd0);
        send_op(FN_RAISE, 1'b0, 5'd0);
        send_op(FN_RAISE, 1'b1, 5'd31);
        send_op(FN_RAISE, 1'b1, 5'd1);
        send_op(FN_QUERY, 1'b0, 5'd1);
        send_op(FN_QUERY, 1'b1, 5'd31);
        send_op(FN_TICK, 1'b0, 5'd0);
        send_op(FN_TICK, 1'b0, 5'd0);
        send_op(FN_CLEAR, 1'b0, 5'd31);
        send_op(FN_CLEAR, 1'b0, 5'd31);
        send_op(FN_RAISE, 1'b0, 5'd1);
        send_op(FN_RAISE, 1'b1, 5'd2);
        send_op(3'd5, 1'b0, 5'd0);
        send_op(3'd7, 1'b1, 5'd31);
        send_op(FN_QUERY, 1'b0, 5'd20);
        send_op(FN_TICK, 1'b1, 5'd3);

        // load the rest with small recovery times so ticks clear faults
        for (int f = 3; f < 31; f++)
            load_fault(5'(f), 8'($urandom_range(0, 4)), 3'($urandom), 3'($urandom),
                       1'($urandom), 16'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0));

        // random: mostly raise/clear/tick sequences, occasional reloads and noise
        for (int i = 0; i < 200; i++) begin
            k = $urandom_range(0, 99);
            e = pick_loaded();
            if (k < 35) send_op(FN_RAISE, 1'($urandom), e);
            else if (k < 55) send_op(FN_CLEAR, 1'($urandom), e);
            else if (k < 70) send_op(FN_TICK, 1'($urandom), 5'($urandom));
            else if (k < 82) send_op(FN_QUERY, 1'($urandom), 5'($urandom));
            else if (k < 95)
                load_fault(5'($urandom), 8'($urandom_range(0, 1) ? $urandom_range(0, 4)
                           : $urandom), 3'($urandom), 3'($urandom), 1'($urandom),
                           16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 3)),
                           1'($urandom));
            else send_op(3'($urandom_range(5, 7)), 1'($urandom), 5'($urandom));
        end
        in_valid <= 1'b0;

        // drain and let the sequencer settle
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
